// ===== rtl/core/dabl_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and sequencer states of the occlusion blur.
package dabl_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 4096;
  localparam int PIX_W         = 16;
  localparam int CFG_WIDTH_W   = 12;
  localparam int CFG_HEIGHT_W  = 13;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_INDEX_W   = 1;
  localparam int ROW_CNT_W     = 13;
  localparam int COL_OUT_W     = 11;
  localparam int ROW_OUT_W     = 12;
  localparam int DEPTH_GAIN    = 100;
  localparam int ONE_Q16       = 65536;
  localparam int DEN_W         = 23;
  localparam int NUM_W         = 35;
  localparam int QUO_W         = 16;
  localparam int WSUM_W        = 19;
  localparam int PROD_W        = 32;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_IMAGE_WIDTH  = 1'b0;
  localparam cfg_index_t REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_START,
    ST_NBR,
    ST_WDIV,
    ST_FSTART,
    ST_FDIV,
    ST_OUT
  } dabl_state_t;

endpackage

// ===== rtl/core/dabl_if.sv =====
`timescale 1ns / 1ps
// Pixel and result channel interfaces.
interface dabl_in_if import dabl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] depth_sample;
  logic [PIX_W-1:0] occlusion_sample;
  modport source (output valid, depth_sample, occlusion_sample, input ready);
  modport sink   (input valid, depth_sample, occlusion_sample, output ready);
endinterface

interface dabl_out_if import dabl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PIX_W-1:0]     blurred_value;
  logic [COL_OUT_W-1:0] out_column;
  logic [ROW_OUT_W-1:0] out_row;
  logic                 last_of_run;
  modport source (output valid, blurred_value, out_column, out_row, last_of_run,
                  input ready);
  modport sink   (input valid, blurred_value, out_column, out_row, last_of_run,
                  output ready);
endinterface

// ===== rtl/core/dabl_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module dabl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/dabl_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
module dabl_div import dabl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [QUO_W-1:0] quotient,
  output logic             done
);
  localparam int DSH_W = DEN_W + QUO_W - 1;
  localparam int CNT_W = $clog2(QUO_W);

  logic [NUM_W-1:0] rem_r;
  logic [DSH_W-1:0] dsh_r;
  logic [QUO_W-1:0] q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             ge;

  assign ge = DSH_W'(rem_r) >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= dividend;
        dsh_r  <= DSH_W'(divisor) << (QUO_W - 1);
        q_r    <= '0;
      end else if (busy_r) begin
        if (ge) begin
          rem_r <= rem_r - dsh_r[NUM_W-1:0];
        end
        q_r   <= {q_r[QUO_W-2:0], ge};
        dsh_r <= dsh_r >> 1;
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign quotient = q_r;
  assign done     = done_r;
endmodule

// ===== rtl/core/depth_aware_occlusion_blur.sv =====
`timescale 1ns / 1ps
// Depth-aware 3x3 bilateral blur of an occlusion stream.
// Takes one pixel (depth, occlusion) at a time in raster order and returns
// blurred results with their column and row, each pixel's result once its
// right and lower neighbours are known, so zero to four results per pixel.
// One pixel is worked at a time: the line store is read in ST_IDLE and
// written in ST_LOAD, then each result walks the nine window positions,
// starting a division for each in-bound neighbour, and waits on
// out_if.ready. The shared 16-step divider forms each neighbour weight
// and the final quotient. in_if.ready is low from acceptance until the
// last result of the pixel is taken. The line store needs no clearing
// after reset.
module depth_aware_occlusion_blur import dabl_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  dabl_in_if.sink                in_if,
  dabl_out_if.source             out_if,
  input  logic                   cfg_wr_en,
  input  cfg_index_t             cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int LW = 4 * PIX_W;

  dabl_state_t state_r, state_nxt;

  logic [CFG_WIDTH_W-1:0]  width_r;
  logic [CFG_HEIGHT_W-1:0] height_r;
  logic [CW-1:0]           eff_w;
  logic [ROW_CNT_W-1:0]    eff_h;

  logic [CW-1:0]        col_r;
  logic [ROW_CNT_W-1:0] row_r;
  logic [CW-1:0]        c_r, c0;
  logic [ROW_CNT_W-1:0] r_r, r0;
  logic [PIX_W-1:0]     dnew_r, onew_r;
  logic                 wrap;

  logic [PIX_W-1:0] dwin_r [3][3];
  logic [PIX_W-1:0] owin_r [3][3];

  logic          ram_we;
  logic [LW-1:0] ram_wdata, ram_rdata;
  logic [PIX_W-1:0] rd_d0, rd_d1, rd_o0, rd_o1;

  logic [3:0] pend_r;
  logic [3:0] pend_new;
  logic [1:0] j;
  logic [1:0] wc, wr;
  logic [CW-1:0]        x;
  logic [ROW_CNT_W-1:0] y;
  logic                 lc, lr;

  logic [1:0] dx_r, dy_r;
  logic [2:0] rs, cs;
  logic [1:0] wrow, wcol;
  logic       oob;
  logic [PIX_W-1:0] dc_r, ds, diff, occ_nb_r;
  logic [DEN_W-1:0] denom;
  logic [NUM_W-1:0] num_r;
  logic [WSUM_W-1:0] wsum_r;
  logic [PROD_W-1:0] prod;
  logic              adv_last;

  logic             div_start, div_done;
  logic [NUM_W-1:0] div_dividend;
  logic [DEN_W-1:0] div_divisor;
  logic [QUO_W-1:0] div_q;

  logic [PIX_W-1:0]     res_val_r;
  logic [COL_OUT_W-1:0] res_col_r;
  logic [ROW_OUT_W-1:0] res_row_r;
  logic                 res_last_r;
  logic [3:0]           rest;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_WIDTH_W'(64);
      height_r <= CFG_HEIGHT_W'(64);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wr_data[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wr_data[CFG_HEIGHT_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      eff_w = CW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = ROW_CNT_W'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      eff_h = ROW_CNT_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  assign wrap = (col_r >= eff_w) || (row_r >= eff_h);
  assign c0   = wrap ? '0 : col_r;
  assign r0   = wrap ? '0 : row_r;

  // line store: {row r-2 depth, row r-1 depth, row r-2 occ, row r-1 occ}
  assign {rd_d0, rd_d1, rd_o0, rd_o1} = ram_rdata;
  assign ram_we    = (state_r == ST_LOAD);
  assign ram_wdata = {rd_d1, dnew_r, rd_o1, onew_r};

  dabl_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (c0[AW-1:0]),
    .rdata (ram_rdata)
  );

  // result selection: bit 0 picks the current column, bit 1 the current row
  always_comb begin
    priority if (pend_r[0]) j = 2'd0;
    else if (pend_r[1])     j = 2'd1;
    else if (pend_r[2])     j = 2'd2;
    else                    j = 2'd3;
  end

  assign wc   = j[0] ? 2'd2 : 2'd1;
  assign wr   = j[1] ? 2'd2 : 2'd1;
  assign x    = j[0] ? c_r : c_r - 1'b1;
  assign y    = j[1] ? r_r : r_r - 1'b1;
  assign lc   = (c_r == eff_w - 1'b1);
  assign lr   = (r_r == eff_h - 1'b1);
  assign rest = pend_r & ~(4'b0001 << j);
  assign pend_new = {lc & lr, lr & (c_r != '0), lc & (r_r != '0),
                     (c_r != '0) & (r_r != '0)};

  // neighbour walk
  assign rs   = {1'b0, wr} + {1'b0, dy_r};
  assign cs   = {1'b0, wc} + {1'b0, dx_r};
  assign wrow = 2'(rs - 3'd1);
  assign wcol = 2'(cs - 3'd1);
  assign oob  = (rs == 3'd4) || (cs == 3'd4) ||
                (dy_r == 2'd0 && y == '0) || (dy_r == 2'd2 && y == eff_h - 1'b1) ||
                (dx_r == 2'd0 && x == '0) || (dx_r == 2'd2 && x == eff_w - 1'b1);
  assign ds    = dwin_r[wrow][wcol];
  assign diff  = (dc_r > ds) ? dc_r - ds : ds - dc_r;
  assign denom = DEN_W'(ONE_Q16) + DEN_W'(diff) * DEN_W'(DEPTH_GAIN);
  assign prod  = PROD_W'(occ_nb_r) * PROD_W'(div_q);
  assign adv_last = (dx_r == 2'd2) && (dy_r == 2'd2);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = NUM_W'(32'h8000_0000);
    div_divisor  = denom;
    if (state_r == ST_NBR && !oob) begin
      div_start = 1'b1;
    end else if (state_r == ST_FSTART) begin
      div_start    = 1'b1;
      div_dividend = num_r;
      div_divisor  = DEN_W'(wsum_r);
    end
  end

  dabl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_if.valid) state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = (pend_new != '0) ? ST_START : ST_IDLE;
      ST_START:  state_nxt = ST_NBR;
      ST_NBR:    if (!oob) state_nxt = ST_WDIV;
                 else if (adv_last) state_nxt = ST_FSTART;
      ST_WDIV:   if (div_done) state_nxt = adv_last ? ST_FSTART : ST_NBR;
      ST_FSTART: state_nxt = ST_FDIV;
      ST_FDIV:   if (div_done) state_nxt = ST_OUT;
      ST_OUT:    if (out_if.ready) state_nxt = (rest == '0) ? ST_IDLE : ST_START;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          dwin_r[a][b] <= '0;
          owin_r[a][b] <= '0;
        end
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_if.valid) begin
            c_r    <= c0;
            r_r    <= r0;
            dnew_r <= in_if.depth_sample;
            onew_r <= in_if.occlusion_sample;
            if (c0 == eff_w - 1'b1) begin
              col_r <= '0;
              row_r <= (r0 == eff_h - 1'b1) ? '0 : r0 + 1'b1;
            end else begin
              col_r <= c0 + 1'b1;
              row_r <= r0;
            end
          end
        end
        ST_LOAD: begin
          for (int a = 0; a < 3; a++) begin
            dwin_r[a][0] <= dwin_r[a][1];
            dwin_r[a][1] <= dwin_r[a][2];
            owin_r[a][0] <= owin_r[a][1];
            owin_r[a][1] <= owin_r[a][2];
          end
          dwin_r[0][2] <= rd_d0;
          dwin_r[1][2] <= rd_d1;
          dwin_r[2][2] <= dnew_r;
          owin_r[0][2] <= rd_o0;
          owin_r[1][2] <= rd_o1;
          owin_r[2][2] <= onew_r;
          pend_r <= pend_new;
        end
        ST_START: begin
          dc_r   <= dwin_r[wr][wc];
          num_r  <= '0;
          wsum_r <= '0;
          dx_r   <= 2'd0;
          dy_r   <= 2'd0;
        end
        ST_NBR: begin
          occ_nb_r <= owin_r[wrow][wcol];
          if (oob) begin
            if (dx_r == 2'd2) begin
              dx_r <= 2'd0;
              if (dy_r != 2'd2) dy_r <= dy_r + 1'b1;
            end else begin
              dx_r <= dx_r + 1'b1;
            end
          end
        end
        ST_WDIV: begin
          if (div_done) begin
            num_r  <= num_r + NUM_W'(prod);
            wsum_r <= wsum_r + WSUM_W'(div_q);
            if (dx_r == 2'd2) begin
              dx_r <= 2'd0;
              if (dy_r != 2'd2) dy_r <= dy_r + 1'b1;
            end else begin
              dx_r <= dx_r + 1'b1;
            end
          end
        end
        ST_FSTART: ;
        ST_FDIV: begin
          if (div_done) begin
            res_val_r  <= div_q;
            res_col_r  <= COL_OUT_W'(x);
            res_row_r  <= ROW_OUT_W'(y);
            res_last_r <= (rest == '0);
          end
        end
        ST_OUT: begin
          if (out_if.ready) pend_r <= rest;
        end
      endcase
    end
  end

  assign in_if.ready          = (state_r == ST_IDLE);
  assign out_if.valid         = (state_r == ST_OUT);
  assign out_if.blurred_value = res_val_r;
  assign out_if.out_column    = res_col_r;
  assign out_if.out_row       = res_row_r;
  assign out_if.last_of_run   = res_last_r;
endmodule

// ===== rtl/core/dabl_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the occlusion blur, bound to the top level.
module dabl_checker import dabl_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [PIX_W-1:0]     out_value,
  input logic [COL_OUT_W-1:0] out_col,
  input logic [ROW_OUT_W-1:0] out_row_v,
  input logic                 out_last
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("input taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready straight after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_value) && $stable(out_col) &&
                                  $stable(out_row_v) && $stable(out_last)))
    else $error("result changed while stalled");
endmodule

bind depth_aware_occlusion_blur dabl_checker u_dabl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_value (out_if.blurred_value),
  .out_col   (out_if.out_column),
  .out_row_v (out_if.out_row),
  .out_last  (out_if.last_of_run)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for depth_aware_occlusion_blur: directed and random pixel streams.
module tb;
  import dabl_pkg::*;

  typedef struct {
    logic [PIX_W-1:0]     value;
    logic [COL_OUT_W-1:0] column;
    logic [ROW_OUT_W-1:0] row;
    logic                 last;
  } blur_res_t;

  typedef struct {
    int unsigned      width_reg;
    int unsigned      height_reg;
    logic [PIX_W-1:0] depth;
    logic [PIX_W-1:0] occl;
    bit               known;
    logic [PIX_W-1:0] value;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  cfg_index_t cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  dabl_in_if  in_ch ();
  dabl_out_if out_ch ();

  depth_aware_occlusion_blur u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // predictor state
  int unsigned       width_reg = 64, height_reg = 64;
  logic [PIX_W-1:0]  dline [2][MAX_WIDTH_DEF];
  logic [PIX_W-1:0]  oline [2][MAX_WIDTH_DEF];
  logic [PIX_W-1:0]  dwin [3][3];
  logic [PIX_W-1:0]  owin [3][3];
  int unsigned       col_pos, row_pos;
  blur_res_t         pending_blur[$];

  int errors = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_off = 0;

  function automatic int unsigned used_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return width_reg;
  endfunction

  function automatic int unsigned used_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic logic [PIX_W-1:0] weighted_mean(int wc, int wr, int x, int y,
                                                     int w, int h);
    longint unsigned num, wsum, wt, diff;
    int r, c;
    num = 0;
    wsum = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        r = wr + dy;
        c = wc + dx;
        if (r >= 0 && r <= 2 && y + dy >= 0 && y + dy < h &&
            c >= 0 && c <= 2 && x + dx >= 0 && x + dx < w) begin
          diff = (dwin[wr][wc] > dwin[r][c]) ? dwin[wr][wc] - dwin[r][c]
                                               : dwin[r][c] - dwin[wr][wc];
          wt = 64'h8000_0000 / (65536 + 100 * diff);
          num += owin[r][c] * wt;
          wsum += wt;
        end
      end
    end
    return PIX_W'(num / wsum);
  endfunction

  function automatic void push_res(logic [PIX_W-1:0] v, int x, int y);
    blur_res_t res;
    res.value  = v;
    res.column = COL_OUT_W'(x);
    res.row    = ROW_OUT_W'(y);
    res.last   = 1'b0;
    pending_blur.push_back(res);
  endfunction

  function automatic int blur_pixel(logic [PIX_W-1:0] d, logic [PIX_W-1:0] o);
    int w, h, c, r, n;
    w = used_width();
    h = used_height();
    n = 0;
    if (col_pos >= w || row_pos >= h) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    for (int i = 0; i < 3; i++) begin
      dwin[i][0] = dwin[i][1]; dwin[i][1] = dwin[i][2];
      owin[i][0] = owin[i][1]; owin[i][1] = owin[i][2];
    end
    dwin[0][2] = dline[0][c]; dwin[1][2] = dline[1][c]; dwin[2][2] = d;
    owin[0][2] = oline[0][c]; owin[1][2] = oline[1][c]; owin[2][2] = o;
    dline[0][c] = dline[1][c]; dline[1][c] = d;
    oline[0][c] = oline[1][c]; oline[1][c] = o;
    if (r >= 1 && c >= 1) begin
      push_res(weighted_mean(1, 1, c - 1, r - 1, w, h), c - 1, r - 1); n++;
    end
    if (r >= 1 && c + 1 == w) begin
      push_res(weighted_mean(2, 1, c, r - 1, w, h), c, r - 1); n++;
    end
    if (r + 1 == h && c >= 1) begin
      push_res(weighted_mean(1, 2, c - 1, r, w, h), c - 1, r); n++;
    end
    if (r + 1 == h && c + 1 == w) begin
      push_res(weighted_mean(2, 2, c, r, w, h), c, r); n++;
    end
    if (n > 0) pending_blur[$].last = 1'b1;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
    return n;
  endfunction

  task automatic write_reg(cfg_index_t idx, int unsigned data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= CFG_DATA_W'(data);
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) width_reg = data & 12'hFFF;
    else height_reg = data & 13'h1FFF;
  endtask

  task automatic wait_drained();
    while (pending_blur.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_wr_en <= 1'b0;
  endtask

  // returns the number of results predicted for the pixel
  task automatic send_pixel(logic [PIX_W-1:0] d, logic [PIX_W-1:0] o, output int n);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.depth_sample     <= d;
    in_ch.occlusion_sample <= o;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    n = blur_pixel(d, o);
  endtask

  // result side: stall pattern and checking
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_blur.size() == 0) begin
          $error("unexpected transaction: col %0d row %0d", out_ch.out_column, out_ch.out_row);
          errors++;
        end else begin
          blur_res_t e;
          e = pending_blur.pop_front();
          if (out_ch.blurred_value !== e.value) begin
            $error("blurred_value: expected %0h, got %0h", e.value, out_ch.blurred_value);
            errors++;
          end
          if (out_ch.out_column !== e.column) begin
            $error("out_column: expected %0d, got %0d", e.column, out_ch.out_column);
            errors++;
          end
          if (out_ch.out_row !== e.row) begin
            $error("out_row: expected %0d, got %0d", e.row, out_ch.out_row);
            errors++;
          end
          if (out_ch.last_of_run !== e.last) begin
            $error("last_of_run: expected %0b, got %0b", e.last, out_ch.last_of_run);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off     <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  pixel_row_t directed[$] = '{
    '{1, 1, 16'h0000, 16'h0000, 1, 16'h0000},
    '{1, 1, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF},
    '{1, 1, 16'h0000, 16'hFFFF, 1, 16'hFFFF},
    '{1, 1, 16'hFFFF, 16'h0000, 1, 16'h0000},
    '{0, 0, 16'h1234, 16'hABCD, 1, 16'hABCD},
    '{2, 2, 16'h0000, 16'hFFFF, 0, 16'h0000},
    '{2, 2, 16'hFFFF, 16'h0000, 0, 16'h0000},
    '{2, 2, 16'h8000, 16'h5555, 0, 16'h0000},
    '{2, 2, 16'h8001, 16'hAAAA, 0, 16'h0000},
    '{3, 3, 16'h0100, 16'h1000, 0, 16'h0000},
    '{3, 3, 16'h0101, 16'hF000, 0, 16'h0000},
    '{3, 3, 16'h0000, 16'h0001, 0, 16'h0000},
    '{3, 3, 16'hFFFE, 16'h8000, 0, 16'h0000},
    '{3, 3, 16'h0102, 16'h7FFF, 0, 16'h0000},
    '{3, 3, 16'h0100, 16'h0000, 0, 16'h0000},
    '{3, 3, 16'h4000, 16'hFFFF, 0, 16'h0000},
    '{3, 3, 16'h4001, 16'h1234, 0, 16'h0000},
    '{3, 3, 16'h3FFF, 16'h4321, 0, 16'h0000},
    '{4095, 1, 16'h0010, 16'h0F0F, 0, 16'h0000},
    '{4095, 1, 16'h0011, 16'hF0F0, 0, 16'h0000},
    '{4095, 1, 16'hFFFF, 16'h00FF, 0, 16'h0000},
    '{1, 8191, 16'h0020, 16'hFF00, 0, 16'h0000},
    '{1, 8191, 16'h0020, 16'h00FF, 0, 16'h0000},
    '{1, 8191, 16'hFFFF, 16'h0000, 0, 16'h0000}
  };

  initial begin
    int n, seg, w, h;
    logic [PIX_W-1:0] base, d;
    in_ch.valid            = 1'b0;
    in_ch.depth_sample     = '0;
    in_ch.occlusion_sample = '0;
    out_ch.ready           = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry is 64x64: part of a first row, no transaction expected
    for (int i = 0; i < 3; i++) send_pixel(16'(i), 16'(i * 100), n);

    foreach (directed[i]) begin
      if (directed[i].width_reg != width_reg || directed[i].height_reg != height_reg) begin
        in_ch.valid <= 1'b0;
        set_geometry(directed[i].width_reg, directed[i].height_reg);
      end
      send_pixel(directed[i].depth, directed[i].occl, n);
      if (directed[i].known && n == 1) pending_blur[$].value = directed[i].value;
    end

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 67 : 0;
      recv_idle_pct = (mode == 0) ? 67 : (mode == 1) ? 8 : 0;
      seg = 0;
      while (seg < 45) begin
        case ($urandom_range(9))
          0:       begin w = $urandom_range(2049, 4095); h = $urandom_range(1, 2); end
          1:       begin w = $urandom_range(0, 1); h = $urandom_range(4097, 8191); end
          default: begin w = $urandom_range(1, 6); h = $urandom_range(1, 5); end
        endcase
        // the long receiver stall needs a frame that produces results
        if (mode == 0 && seg == 0) begin
          w = 3;
          h = 3;
        end
        in_ch.valid <= 1'b0;
        set_geometry(w, h);
        if (mode == 0 && seg == 0) hold_off <= 400;
        base = 16'($urandom);
        // mostly close depths so weights vary, sometimes wide jumps
        for (int k = $urandom_range(4, 14); k > 0; k--) begin
          d = ($urandom_range(3) == 0) ? 16'($urandom) : base + 16'($urandom_range(0, 600));
          send_pixel(d, 16'($urandom), n);
          seg++;
        end
      end
    end
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("[depth_aware_occlusion_blur] OK");
    end else begin
      $display("[depth_aware_occlusion_blur] ERROR");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("[depth_aware_occlusion_blur] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dabl_pkg.sv
rtl/core/dabl_if.sv
rtl/core/dabl_ram.sv
rtl/core/dabl_div.sv
rtl/core/depth_aware_occlusion_blur.sv
rtl/core/dabl_checker.sv
tb/tb.sv
